/* sv/sha256_one_word_preimage_check_assert.svh */
// Assertion macros shared by the one-word SHA-256 check block.
// Needs nothing else; included by the modules that assert.
`ifndef SHA256_ONE_WORD_PREIMAGE_CHECK_ASSERT_SVH
`define SHA256_ONE_WORD_PREIMAGE_CHECK_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define S1WPC_ASSERT_SAME(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("s1wpc check failed");

// The consequent must hold in the cycle after the antecedent.
`define S1WPC_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("s1wpc check failed");

`endif

/* sv/s1wpc_pkg.sv */
// Package for the one-word SHA-256 check block: types, constants and round functions.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package s1wpc_pkg;

  typedef logic [31:0] word_t;

  typedef struct packed {
    word_t [7:0]  v;
    word_t [15:0] w;
  } s1wpc_stage_t;

  typedef struct packed {
    word_t [7:0] d;
    logic        m;
  } s1wpc_result_t;

  localparam int unsigned ROUNDS = 64;
  localparam int unsigned ADDR_W = 4;

  localparam logic [1:0] REG_DIGEST_SEL   = 2'd0;
  localparam logic [1:0] REG_MATCH_MASK   = 2'd1;
  localparam logic [1:0] REG_TARGET_VALUE = 2'd2;

  localparam logic [2:0] DIGEST_SEL_RST   = 3'd4;
  localparam word_t      MATCH_MASK_RST   = 32'hffffffff;
  localparam word_t      TARGET_VALUE_RST = 32'h00000000;

  localparam word_t [7:0] INIT_HASH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h00000000;
    endcase
    return k;
  endfunction

endpackage

/* sv/s1wpc_round_cell.sv */
// One SHA-256 round cell: a round of the working state and one schedule step.
// Depends on s1wpc_pkg.
`timescale 1ns / 1ps

module s1wpc_round_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  s1wpc_pkg::word_t       k,
  input  logic                   in_valid,
  input  s1wpc_pkg::s1wpc_stage_t in_stage,
  output logic                   out_valid,
  output s1wpc_pkg::s1wpc_stage_t out_stage
);
  import s1wpc_pkg::*;

  word_t        t1;
  word_t        t2;
  word_t        ch;
  word_t        maj;
  word_t        sched_new;
  s1wpc_stage_t stage_next;

  always_comb begin
    ch  = (in_stage.v[4] & in_stage.v[5]) ^ (~in_stage.v[4] & in_stage.v[6]);
    maj = (in_stage.v[0] & in_stage.v[1]) ^ (in_stage.v[0] & in_stage.v[2]) ^
          (in_stage.v[1] & in_stage.v[2]);
    t1 = in_stage.v[7] + big_sigma1(in_stage.v[4]) + ch + k + in_stage.w[0];
    t2 = big_sigma0(in_stage.v[0]) + maj;
    sched_new = small_sigma1(in_stage.w[14]) + in_stage.w[9] +
                small_sigma0(in_stage.w[1]) + in_stage.w[0];
    stage_next.v[7] = in_stage.v[6];
    stage_next.v[6] = in_stage.v[5];
    stage_next.v[5] = in_stage.v[4];
    stage_next.v[4] = in_stage.v[3] + t1;
    stage_next.v[3] = in_stage.v[2];
    stage_next.v[2] = in_stage.v[1];
    stage_next.v[1] = in_stage.v[0];
    stage_next.v[0] = t1 + t2;
    stage_next.w[14:0] = in_stage.w[15:1];
    stage_next.w[15] = sched_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_stage <= stage_next;
    end
  end

endmodule

/* sv/s1wpc_digest.sv */
// Final cell: adds the initial hash value back into the working state.
// Depends on s1wpc_pkg.
`timescale 1ns / 1ps

module s1wpc_digest (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  s1wpc_pkg::s1wpc_stage_t in_stage,
  output logic                    out_valid,
  output s1wpc_pkg::word_t [7:0]  digest
);
  import s1wpc_pkg::*;

  word_t [7:0] digest_next;

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      digest_next[j] = in_stage.v[j] + INIT_HASH[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      digest <= digest_next;
    end
  end

endmodule

/* sv/sha256_one_word_preimage_check.sv */
// Takes one 32-bit word a cycle as message word 0 of an otherwise zero, unpadded block and
// returns the SHA-256 compression digest plus a masked match flag. The rounds run in a chain
// of 64 round cells, one per round, followed by a digest cell and an output register, so a
// word is accepted every cycle while the skid register is empty. The output register and a
// skid register hold two results between them; the whole chain and the input stall while
// the skid register is full. Registers at byte addresses 0, 4 and 8 select the digest word,
// the compare mask and the target value.
`timescale 1ns / 1ps

module sha256_one_word_preimage_check (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [s1wpc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       message_valid,
  output logic                       message_stall,
  input  logic [31:0]                message_word,
  output logic                       digest_valid,
  input  logic                       digest_stall,
  output logic [31:0]                digest_0,
  output logic [31:0]                digest_1,
  output logic [31:0]                digest_2,
  output logic [31:0]                digest_3,
  output logic [31:0]                digest_4,
  output logic [31:0]                digest_5,
  output logic [31:0]                digest_6,
  output logic [31:0]                digest_7,
  output logic                       is_match
);
  import s1wpc_pkg::*;
  `include "sha256_one_word_preimage_check_assert.svh"

  logic [2:0]    digest_sel;
  word_t         match_mask;
  word_t         target_value;
  logic          cfg_write;
  logic [1:0]    cfg_index;

  logic                   adv;
  logic [ROUNDS:0]        stage_valid;
  s1wpc_stage_t [ROUNDS:0] stage;
  logic                   last_valid;
  word_t [7:0]            last_digest;
  s1wpc_result_t          last_result;
  s1wpc_result_t          out_result;
  s1wpc_result_t          skid_result;
  logic                   skid_valid;
  logic                   take;

  assign pready    = 1'b1;
  assign cfg_index = paddr[3:2];
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      digest_sel   <= DIGEST_SEL_RST;
      match_mask   <= MATCH_MASK_RST;
      target_value <= TARGET_VALUE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DIGEST_SEL:   digest_sel   <= pwdata[2:0];
        REG_MATCH_MASK:   match_mask   <= pwdata;
        REG_TARGET_VALUE: target_value <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_DIGEST_SEL:   prdata = {29'b0, digest_sel};
      REG_MATCH_MASK:   prdata = match_mask;
      REG_TARGET_VALUE: prdata = target_value;
      default:          prdata = 32'h0;
    endcase
  end

  assign adv           = ~skid_valid;
  assign message_stall = skid_valid;

  assign stage_valid[0] = message_valid;
  assign stage[0]       = {INIT_HASH, 480'h0, message_word};

  for (genvar i = 0; i < ROUNDS; i++) begin : g_round
    s1wpc_round_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .k         (round_k(6'(i))),
      .in_valid  (stage_valid[i]),
      .in_stage  (stage[i]),
      .out_valid (stage_valid[i+1]),
      .out_stage (stage[i+1])
    );
  end

  s1wpc_digest u_digest (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (stage_valid[ROUNDS]),
    .in_stage  (stage[ROUNDS]),
    .out_valid (last_valid),
    .digest    (last_digest)
  );

  always_comb begin
    last_result.d = last_digest;
    last_result.m = ((last_digest[digest_sel] & match_mask) == target_value);
  end

  assign take = digest_valid & ~digest_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      digest_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (last_valid) begin
      if (!digest_valid || take) begin
        digest_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      digest_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_result <= skid_result;
      end
    end else if (last_valid) begin
      if (!digest_valid || take) begin
        out_result <= last_result;
      end else begin
        skid_result <= last_result;
      end
    end
  end

  assign digest_0 = out_result.d[0];
  assign digest_1 = out_result.d[1];
  assign digest_2 = out_result.d[2];
  assign digest_3 = out_result.d[3];
  assign digest_4 = out_result.d[4];
  assign digest_5 = out_result.d[5];
  assign digest_6 = out_result.d[6];
  assign digest_7 = out_result.d[7];
  assign is_match = out_result.m;

  `S1WPC_ASSERT_SAME(a_skid_behind_out, clk, rst, skid_valid, digest_valid)
  `S1WPC_ASSERT_NEXT(a_skid_held, clk, rst, skid_valid && digest_stall, skid_valid)
  `S1WPC_ASSERT_NEXT(a_drain_empties, clk, rst,
    take && !skid_valid && !last_valid, !digest_valid)
  `S1WPC_ASSERT_NEXT(a_entry_captured, clk, rst,
    message_valid && !message_stall, stage_valid[1])

endmodule

/* bench/tb_sha256_one_word_preimage_check.sv */
// Testbench for sha256_one_word_preimage_check: directed and random message words with
// a self-computed one-word SHA-256 digest and match flag, checked against every result.
// Depends on s1wpc_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_sha256_one_word_preimage_check;
  import s1wpc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 100;
  localparam logic [1:0]  REG_SPARE   = 2'd3;

  localparam logic [0:7][31:0] HASH_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [0:63][31:0] ROUND_CONST = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [7:0][31:0] dw;
    logic             match;
  } digest_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                message_valid = 1'b0;
  logic                message_stall;
  logic [31:0]         message_word = '0;
  logic                digest_valid;
  logic                digest_stall = 1'b0;
  logic [31:0]         digest_0, digest_1, digest_2, digest_3;
  logic [31:0]         digest_4, digest_5, digest_6, digest_7;
  logic                is_match;

  logic [2:0]          cfg_digest_sel = 3'd4;
  logic [31:0]         cfg_match_mask = 32'hffffffff;
  logic [31:0]         cfg_target_value = 32'h00000000;

  digest_t             digest_expect_q[$];
  int unsigned         error_count = 0;
  int unsigned         cycle_count = 0;
  int unsigned         tx_idle_pct = 0;
  int unsigned         rx_stall_pct = 0;
  logic                hold_req = 1'b0;
  int unsigned         hold_left = 0;

  sha256_one_word_preimage_check DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .message_valid(message_valid), .message_stall(message_stall),
    .message_word(message_word),
    .digest_valid(digest_valid), .digest_stall(digest_stall),
    .digest_0(digest_0), .digest_1(digest_1), .digest_2(digest_2), .digest_3(digest_3),
    .digest_4(digest_4), .digest_5(digest_5), .digest_6(digest_6), .digest_7(digest_7),
    .is_match(is_match)
  );

  always #10 clk = ~clk;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [7:0][31:0] sha256_one_word(input logic [31:0] w);
    logic [31:0]      sched [0:63];
    logic [31:0]      a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    logic [7:0][31:0] r;
    for (int i = 0; i < 16; i++) sched[i] = 32'h0;
    sched[0] = w;
    for (int i = 16; i < 64; i++) begin
      s0 = ror(sched[i-15], 7) ^ ror(sched[i-15], 18) ^ (sched[i-15] >> 3);
      s1 = ror(sched[i-2], 17) ^ ror(sched[i-2], 19) ^ (sched[i-2] >> 10);
      sched[i] = s1 + sched[i-7] + s0 + sched[i-16];
    end
    a = HASH_IV[0]; b = HASH_IV[1]; c = HASH_IV[2]; d = HASH_IV[3];
    e = HASH_IV[4]; f = HASH_IV[5]; g = HASH_IV[6]; h = HASH_IV[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
           + ROUND_CONST[i] + sched[i];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    r[0] = a + HASH_IV[0]; r[1] = b + HASH_IV[1]; r[2] = c + HASH_IV[2];
    r[3] = d + HASH_IV[3]; r[4] = e + HASH_IV[4]; r[5] = f + HASH_IV[5];
    r[6] = g + HASH_IV[6]; r[7] = h + HASH_IV[7];
    return r;
  endfunction

  function automatic digest_t hash_and_match(input logic [31:0] w);
    digest_t r;
    r.dw = sha256_one_word(w);
    r.match = ((r.dw[cfg_digest_sel] & cfg_match_mask) == cfg_target_value);
    return r;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_left != 0) begin
      digest_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      digest_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else begin
      digest_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    digest_t got, want;
    if (!rst) begin
      if (message_valid && !message_stall) begin
        digest_expect_q.push_back(hash_and_match(message_word));
      end
      if (digest_valid && !digest_stall) begin
        got.dw = {digest_7, digest_6, digest_5, digest_4,
                  digest_3, digest_2, digest_1, digest_0};
        got.match = is_match;
        if (digest_expect_q.size() == 0) begin
          $error("digest word arrived with no prediction waiting");
          error_count++;
        end else begin
          want = digest_expect_q.pop_front();
          for (int i = 0; i < 8; i++) begin
            if (got.dw[i] !== want.dw[i]) begin
              $error("digest_%0d expected %h got %h", i, want.dw[i], got.dw[i]);
              error_count++;
            end
          end
          if (got.match !== want.match) begin
            $error("is_match expected %b got %b", want.match, got.match);
            error_count++;
          end
        end
      end
    end
  end

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_DIGEST_SEL:   cfg_digest_sel = data[2:0];
      REG_MATCH_MASK:   cfg_match_mask = data;
      REG_TARGET_VALUE: cfg_target_value = data;
      default: ;
    endcase
  endtask

  task automatic apb_read_check(input logic [1:0] idx, input logic [31:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_W'({idx, 2'b00});
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      $error("prdata expected %h got %h", want, prdata);
      error_count++;
    end
  endtask

  task automatic apb_release();
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(input logic [31:0] sel_data, input logic [31:0] mask,
                            input logic [31:0] value);
    apb_write(REG_DIGEST_SEL, sel_data);
    apb_write(REG_MATCH_MASK, mask);
    apb_write(REG_TARGET_VALUE, value);
    apb_release();
  endtask

  task automatic send_word(input logic [31:0] w);
    while ($urandom_range(99) < tx_idle_pct) begin
      message_valid <= 1'b0;
      message_word <= $urandom;
      @(posedge clk);
    end
    message_valid <= 1'b1;
    message_word <= w;
    @(posedge clk);
    while (message_stall) @(posedge clk);
  endtask

  task automatic drain();
    message_valid <= 1'b0;
    @(posedge clk);
    while (digest_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_reset_config();
    apb_read_check(REG_DIGEST_SEL, {29'b0, DIGEST_SEL_RST});
    apb_read_check(REG_MATCH_MASK, MATCH_MASK_RST);
    apb_read_check(REG_TARGET_VALUE, TARGET_VALUE_RST);
    apb_release();
    send_word(32'h00000000);
    send_word(32'hffffffff);
    send_word(32'haaaaaaaa);
    send_word(32'h55555555);
    drain();
  endtask

  task automatic test_match_each_word();
    logic [31:0]      w;
    logic [7:0][31:0] d;
    for (int tw = 0; tw < 8; tw++) begin
      w = $urandom;
      d = sha256_one_word(w);
      set_config(tw, 32'hffffffff, d[tw]);
      send_word(w);
      drain();
    end
  endtask

  task automatic test_mask_cases();
    logic [31:0]      w;
    logic [7:0][31:0] d;
    w = $urandom;
    d = sha256_one_word(w);
    set_config(32'd2, 32'h00000000, 32'h00000000);
    send_word(w);
    drain();
    set_config(32'd2, 32'h00000000, 32'h00000001);
    send_word(w);
    drain();
    // The low half matches, but the target has a bit set where the mask is clear.
    set_config(32'd5, 32'h0000ffff, (d[5] & 32'h0000ffff) | 32'h80000000);
    send_word(w);
    drain();
    // Only the low three bits of the index are kept; a write past the last register
    // must leave every register alone.
    apb_write(REG_TARGET_VALUE, d[3]);
    apb_write(REG_MATCH_MASK, 32'hffffffff);
    apb_write(REG_DIGEST_SEL, 32'hfffffffb);
    apb_write(REG_SPARE, 32'h00000006);
    apb_release();
    send_word(w);
    send_word(~w);
    drain();
  endtask

  task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
                                     input int unsigned n_words);
    logic [31:0] mask;
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    for (int seg = 0; seg < 6; seg++) begin
      mask = $urandom & $urandom & $urandom;
      case (seg)
        0: set_config(32'd0, 32'hffffffff, 32'h00000000);
        1: set_config(32'd7, 32'h00000000, 32'h00000000);
        2: set_config(32'd7, 32'h00000000, 32'hffffffff);
        3: set_config($urandom_range(7), 32'hffffffff, 32'hffffffff);
        default: set_config($urandom, mask, $urandom & mask);
      endcase
      repeat (n_words / 6) send_word($urandom);
      drain();
    end
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    set_config($urandom, 32'h0000000f, $urandom_range(15));
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    repeat (300) send_word($urandom);
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_config();
    test_match_each_word();
    test_mask_cases();
    test_random_traffic(9, 80, 360);
    test_random_traffic(80, 9, 360);
    test_random_traffic(0, 0, 360);
    test_backpressure();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
